### hdl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants
// Payload structs, controller states and command/status bundles for the
// cylindrical diffusion tensor core.
// ----------------------------------------------------------------------------
package cdt_pkg;

   localparam int MAX_TERMS = 8;

   localparam logic [1:0] OP_EVAL   = 2'd0;
   localparam logic [1:0] OP_WR_R   = 2'd1;
   localparam logic [1:0] OP_WR_A   = 2'd2;
   localparam logic [1:0] OP_IGNORE = 2'd3;

   localparam logic [1:0] REG_RADIAL_TERMS = 2'd0;
   localparam logic [1:0] REG_AXIAL_TERMS  = 2'd1;
   localparam logic [1:0] REG_DERIV_MODE   = 2'd2;

   localparam logic [1:0] MODE_VALUE  = 2'd0;
   localparam logic [1:0] MODE_RADIAL = 2'd1;
   localparam logic [1:0] MODE_AXIAL  = 2'd2;

   localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [30:0]        radius;
      logic [15:0]        angle;
      logic signed [31:0] axial_position;
      logic [2:0]         coeff_index;
      logic signed [31:0] coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tensor_xx;
      logic signed [31:0] tensor_xy;
      logic signed [31:0] tensor_yy;
      logic signed [31:0] tensor_zz;
      logic               saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOP, ST_TRIG, ST_MUL, ST_ROUND, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture item, init Horner and CORDIC
      logic step;      // one Horner step and one CORDIC step
      logic trig;      // trig products
      logic mul;       // tensor products
      logic round;     // round and saturate
      logic out_load;  // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;      // both loops finished
   } sts_type;

   function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   // Saturate a 66-bit value to 32 bits, flag clipping
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647)       r = {1'b1, 32'h7FFFFFFF};
      else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
      else                           r = {1'b0, v[31:0]};
      return r;
   endfunction

endpackage

### hdl/cylindrical_diffusion_tensor_core.sv
// ----------------------------------------------------------------------------
// cylindrical_diffusion_tensor_core: Horner and CORDIC tensor evaluator
// Evaluates radial/axial polynomials and angle trig into a Q16.16 tensor.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per valid/stall handshake. Opcode evaluate
//   starts a computation; write opcodes update a coefficient table and
//   produce no result.
//   rsp_* returns one item per evaluate from an output register, held
//   while rsp_stall is high.
//   csr_* writes the term counts and derivative mode; the user must write
//   them only while idle, as the block itself does not enforce it.
// Sequencing:
//   An evaluate runs a loop (one CORDIC rotation and one Horner step per
//   cycle), a check of the loop end, then trig products, tensor products,
//   rounding and output. The CORDIC iteration sets the loop length at
//   CORDIC_STEPS = 16. The next item is taken the cycle after the result
//   enters the output register; no new item is taken during an evaluate.
// Reset:
//   Synchronous; tables return to 1.0 at entry 0, counts to 1, mode to 0.
// ----------------------------------------------------------------------------
module cylindrical_diffusion_tensor_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cdt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdt_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [3:0]       csr_index,
   input  logic [3:0]       csr_data
);

   cdt_pkg::cmd_type cmd;
   cdt_pkg::sts_type sts;

   cdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdt_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp_data)
   );

endmodule

### hdl/cdt_ctrl.sv
// ----------------------------------------------------------------------------
// cdt_ctrl: evaluation sequencer
// Walks one evaluate item through load, loop, trig, product, round and
// output phases; handles the request/response handshake.
// ----------------------------------------------------------------------------
module cdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cdt_pkg::sts_type     sts,
   output cdt_pkg::cmd_type     cmd
);

   cdt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         cdt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_opcode == cdt_pkg::OP_EVAL) state_in = cdt_pkg::ST_LOOP;
            end
         end
         cdt_pkg::ST_LOOP: begin
            if (sts.done) state_in = cdt_pkg::ST_TRIG;
            else cmd.step = 1'b1;
         end
         cdt_pkg::ST_TRIG: begin
            cmd.trig = 1'b1;
            state_in = cdt_pkg::ST_MUL;
         end
         cdt_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = cdt_pkg::ST_ROUND;
         end
         cdt_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = cdt_pkg::ST_OUT;
         end
         cdt_pkg::ST_OUT: begin
            // wait for output register to free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cdt_pkg::ST_IDLE;
            end
         end
         default: state_in = cdt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/cdt_datapath.sv
// ----------------------------------------------------------------------------
// cdt_datapath: coefficient tables, Horner units, CORDIC and products
// One Horner step per polynomial and one CORDIC rotation per cycle, then
// trig products, tensor products and saturation into the output register.
// ----------------------------------------------------------------------------
module cdt_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cdt_pkg::req_type req,
   input  logic             csr_write,
   input  logic [3:0]       csr_index,
   input  logic [3:0]       csr_data,
   input  cdt_pkg::cmd_type cmd,
   output cdt_pkg::sts_type sts,
   output cdt_pkg::rsp_type rsp
);

   localparam int IW = (cdt_pkg::MAX_TERMS > 1) ? $clog2(cdt_pkg::MAX_TERMS) : 1;
   localparam int CW = $clog2(CORDIC_STEPS + 1);

   // configuration
   logic [3:0] radial_terms_ff, axial_terms_ff;
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radial_terms_ff <= 4'd1;
         axial_terms_ff  <= 4'd1;
         mode_ff         <= cdt_pkg::MODE_VALUE;
      end else if (csr_write) begin
         case (csr_index[1:0])
            cdt_pkg::REG_RADIAL_TERMS: if (csr_index[3:2] == 2'd0)
               radial_terms_ff <= csr_data;
            cdt_pkg::REG_AXIAL_TERMS: if (csr_index[3:2] == 2'd0)
               axial_terms_ff <= csr_data;
            cdt_pkg::REG_DERIV_MODE: if (csr_index[3:2] == 2'd0)
               mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // coefficient tables, entry 0 resets to 1.0
   logic signed [31:0] rad_ff [cdt_pkg::MAX_TERMS];
   logic signed [31:0] axi_ff [cdt_pkg::MAX_TERMS];
   logic               wr_ok;
   assign wr_ok = ({29'd0, req.coeff_index} < cdt_pkg::MAX_TERMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdt_pkg::MAX_TERMS; i++) begin
            rad_ff[i] <= (i == 0) ? cdt_pkg::ONE_Q16 : 32'sd0;
            axi_ff[i] <= (i == 0) ? cdt_pkg::ONE_Q16 : 32'sd0;
         end
      end else if (cmd.load && wr_ok) begin
         if (req.opcode == cdt_pkg::OP_WR_R) rad_ff[req.coeff_index[IW-1:0]] <= req.coeff_value;
         if (req.opcode == cdt_pkg::OP_WR_A) axi_ff[req.coeff_index[IW-1:0]] <= req.coeff_value;
      end
   end

   // term counts, clamped
   function automatic logic [5:0] clamp_n(input logic [3:0] n);
      logic [5:0] r;
      if (n == 4'd0) r = 6'd1;
      else if ({2'd0, n} > cdt_pkg::MAX_TERMS) r = 6'(cdt_pkg::MAX_TERMS);
      else r = {2'd0, n};
      return r;
   endfunction

   logic [5:0] nr, na;
   assign nr = clamp_n(radial_terms_ff);
   assign na = clamp_n(axial_terms_ff);

   // Horner state: one polynomial unit per axis
   logic               deriv_r, deriv_a;
   logic signed [31:0] x_r_ff, x_a_ff;
   logic signed [31:0] acc_r_ff, acc_a_ff;
   logic [5:0]         i_r_ff, i_a_ff;   // next coefficient index + 1
   logic               sat_ff;
   logic [1:0]         mode_cap_ff;

   assign deriv_r = (mode_ff == cdt_pkg::MODE_RADIAL);
   assign deriv_a = (mode_ff == cdt_pkg::MODE_AXIAL);

   // coefficient term: plain or k*p_k
   function automatic logic signed [65:0] coeff_term(input logic signed [31:0] p,
                                                     input logic [5:0] k,
                                                     input logic d);
      logic signed [65:0] r;
      if (d) r = 66'(p) * $signed({60'd0, k});
      else   r = 66'(p);
      return r;
   endfunction

   logic signed [31:0] p_r_top, p_a_top, p_r_cur, p_a_cur;
   logic [5:0] top_r, top_a;
   logic [32:0] init_r, init_a, stp_r, stp_a;
   logic signed [65:0] prod_r, prod_a;
   logic done_r, done_a;

   assign top_r   = nr - 6'd1;
   assign top_a   = na - 6'd1;
   assign p_r_top = rad_ff[top_r[IW-1:0]];
   assign p_a_top = axi_ff[top_a[IW-1:0]];
   assign init_r  = cdt_pkg::sat32(coeff_term(p_r_top, top_r, deriv_r));
   assign init_a  = cdt_pkg::sat32(coeff_term(p_a_top, top_a, deriv_a));

   // current step uses index i-1, loop stops at 0 (value) or 1 (deriv)
   logic [5:0] im_r, im_a;
   assign im_r    = i_r_ff - 6'd1;
   assign im_a    = i_a_ff - 6'd1;
   assign p_r_cur = rad_ff[im_r[IW-1:0]];
   assign p_a_cur = axi_ff[im_a[IW-1:0]];
   assign done_r  = deriv_r ? (i_r_ff <= 6'd1) : (i_r_ff == 6'd0);
   assign done_a  = deriv_a ? (i_a_ff <= 6'd1) : (i_a_ff == 6'd0);
   assign prod_r  = 66'(acc_r_ff) * 66'(x_r_ff);
   assign prod_a  = 66'(acc_a_ff) * 66'(x_a_ff);
   assign stp_r   = cdt_pkg::sat32(((prod_r + 66'sd32768) >>> 16)
                                   + coeff_term(p_r_cur, im_r, deriv_r));
   assign stp_a   = cdt_pkg::sat32(((prod_a + 66'sd32768) >>> 16)
                                   + coeff_term(p_a_cur, im_a, deriv_a));

   // clipping in a Horner step counts only for the polynomials in use
   logic step_sat;
   assign step_sat = (!done_r && stp_r[32] && (mode_cap_ff == cdt_pkg::MODE_VALUE ||
                                               mode_cap_ff == cdt_pkg::MODE_RADIAL))
                  || (!done_a && stp_a[32] && (mode_cap_ff == cdt_pkg::MODE_VALUE ||
                                               mode_cap_ff == cdt_pkg::MODE_AXIAL));

   // CORDIC
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [CW-1:0]      ci_ff;
   logic [1:0]         quad_ff;
   logic signed [33:0] dx, dy;
   logic               cdone;
   assign dx    = cy_ff >>> ci_ff;
   assign dy    = cx_ff >>> ci_ff;
   assign cdone = ({{(32-CW){1'b0}}, ci_ff} >= CORDIC_STEPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_r_ff <= '0;
         i_a_ff <= '0;
         ci_ff  <= '0;
      end else if (cmd.load) begin
         x_r_ff      <= {1'b0, req.radius};
         x_a_ff      <= req.axial_position;
         mode_cap_ff <= mode_ff;
         acc_r_ff    <= init_r[31:0];
         acc_a_ff    <= init_a[31:0];
         // each Horner initial value only counts when used
         sat_ff      <= ((mode_ff == cdt_pkg::MODE_VALUE || deriv_r) && init_r[32])
                     || ((mode_ff == cdt_pkg::MODE_VALUE || deriv_a) && init_a[32]);
         i_r_ff      <= top_r;
         i_a_ff      <= top_a;
         cx_ff       <= cdt_pkg::CORDIC_GAIN;
         cy_ff       <= '0;
         cz_ff       <= {4'd0, req.angle[13:0], 16'd0};
         quad_ff     <= req.angle[15:14];
         ci_ff       <= '0;
      end else if (cmd.step) begin
         if (!done_r) begin
            acc_r_ff <= stp_r[31:0];
            i_r_ff   <= im_r;
         end
         if (!done_a) begin
            acc_a_ff <= stp_a[31:0];
            i_a_ff   <= im_a;
         end
         sat_ff <= sat_ff | step_sat;
         if (!cdone) begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - dx;
               cy_ff <= cy_ff + dy;
               cz_ff <= cz_ff - 34'(cdt_pkg::atan_turn(5'(ci_ff)));
            end else begin
               cx_ff <= cx_ff + dx;
               cy_ff <= cy_ff - dy;
               cz_ff <= cz_ff + 34'(cdt_pkg::atan_turn(5'(ci_ff)));
            end
            ci_ff <= ci_ff + 1'b1;
         end
      end
   end

   assign sts.done = done_r && done_a && cdone;

   // quadrant map
   logic signed [33:0] c_v, s_v;
   always_comb begin
      case (quad_ff)
         2'd0:    begin c_v = cx_ff;  s_v = cy_ff;  end
         2'd1:    begin c_v = -cy_ff; s_v = cx_ff;  end
         2'd2:    begin c_v = -cx_ff; s_v = -cy_ff; end
         default: begin c_v = cy_ff;  s_v = -cx_ff; end
      endcase
   end

   // trig products, rounded to Q1.30
   logic signed [67:0] cc_w, sc_w, ss_w;
   logic signed [33:0] cc_ff, sc_ff, ss_ff;
   assign cc_w = 68'(c_v) * 68'(c_v);
   assign sc_w = 68'(s_v) * 68'(c_v);
   assign ss_w = 68'(s_v) * 68'(s_v);

   // tensor products
   logic signed [31:0] k_v;
   logic signed [65:0] pxx_ff, pxy_ff, pyy_ff;
   logic [32:0] rxx, rxy, ryy;
   logic signed [31:0] xx_ff, xy_ff, yy_ff;
   logic               sat2_ff;
   assign k_v = (mode_cap_ff == cdt_pkg::MODE_VALUE)  ? acc_r_ff :
                (mode_cap_ff == cdt_pkg::MODE_RADIAL) ? acc_r_ff : 32'sd0;
   assign rxx = cdt_pkg::sat32((pxx_ff + 66'sd536870912) >>> 30);
   assign rxy = cdt_pkg::sat32((pxy_ff + 66'sd536870912) >>> 30);
   assign ryy = cdt_pkg::sat32((pyy_ff + 66'sd536870912) >>> 30);

   logic tens_on;
   assign tens_on = (mode_cap_ff == cdt_pkg::MODE_VALUE)
                 || (mode_cap_ff == cdt_pkg::MODE_RADIAL);

   always_ff @(posedge clock) begin
      if (cmd.trig) begin
         cc_ff <= 34'((cc_w + 68'sd536870912) >>> 30);
         sc_ff <= 34'((sc_w + 68'sd536870912) >>> 30);
         ss_ff <= 34'((ss_w + 68'sd536870912) >>> 30);
      end
      if (cmd.mul) begin
         pxx_ff <= 66'(cc_ff) * 66'(k_v);
         pxy_ff <= 66'(sc_ff) * 66'(k_v);
         pyy_ff <= 66'(ss_ff) * 66'(k_v);
      end
      if (cmd.round) begin
         xx_ff   <= tens_on ? rxx[31:0] : 32'sd0;
         xy_ff   <= tens_on ? rxy[31:0] : 32'sd0;
         yy_ff   <= tens_on ? ryy[31:0] : 32'sd0;
         sat2_ff <= tens_on && (rxx[32] | rxy[32] | ryy[32]);
      end
      if (cmd.out_load) begin
         rsp.tensor_xx <= xx_ff;
         rsp.tensor_xy <= xy_ff;
         rsp.tensor_yy <= yy_ff;
         rsp.tensor_zz <= (mode_cap_ff == cdt_pkg::MODE_VALUE ||
                           mode_cap_ff == cdt_pkg::MODE_AXIAL) ? acc_a_ff : 32'sd0;
         rsp.saturated <= sat_ff | sat2_ff;
      end
   end

endmodule

### tb/sv/tb_cylindrical_diffusion_tensor_core.sv
// ----------------------------------------------------------------------------
// tb_cylindrical_diffusion_tensor_core: self-checking regression bench
// Drives coefficient writes and evaluate items through the request channel,
// predicts each tensor result in the bench, and compares every returned item
// as a whole. Runs several register settings with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_cylindrical_diffusion_tensor_core;

   localparam int TERMS_MAX   = cdt_pkg::MAX_TERMS;
   localparam int ROT_STEPS   = 16;
   localparam int WATCH_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 60;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   cdt_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   cdt_pkg::rsp_type rsp_data;
   logic       csr_write;
   logic [3:0] csr_index;
   logic [3:0] csr_data;

   cylindrical_diffusion_tensor_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // bench copy of block state
   logic signed [31:0] radial_tab [TERMS_MAX];
   logic signed [31:0] axial_tab [TERMS_MAX];
   logic [3:0] n_radial, n_axial;
   logic [1:0] deriv_mode;

   cdt_pkg::req_type pending_items [$];
   cdt_pkg::rsp_type tensor_expected [$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      hold_rsp = 0;
   bit      pause_req = 0;

   // ---------------------------------------------------------------------
   // Fixed-point helpers
   // ---------------------------------------------------------------------
   function automatic longint rshift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] clip32(longint v, ref bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1;
         return 32'h7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic int used_terms(logic [3:0] n);
      if (n < 1) return 1;
      if (n > TERMS_MAX) return TERMS_MAX;
      return int'(n);
   endfunction

   function automatic logic signed [31:0] horner_value(bit axial, int n,
                                                        longint x, ref bit flag);
      longint acc;
      acc = axial ? axial_tab[n-1] : radial_tab[n-1];
      for (int i = n - 1; i > 0; i--)
         acc = clip32(round_q(acc * x, 16) + (axial ? axial_tab[i-1] : radial_tab[i-1]),
                      flag);
      return acc[31:0];
   endfunction

   function automatic logic signed [31:0] horner_slope(bit axial, int n,
                                                        longint x, ref bit flag);
      longint acc;
      acc = clip32(longint'(n - 1) * (axial ? axial_tab[n-1] : radial_tab[n-1]), flag);
      for (int i = n - 1; i > 1; i--)
         acc = clip32(round_q(acc * x, 16)
                      + longint'(i - 1) * (axial ? axial_tab[i-1] : radial_tab[i-1]),
                      flag);
      return acc[31:0];
   endfunction

   function automatic void rotate_angle(logic [15:0] ang, output longint c,
                                        output longint s);
      longint x, y, z, dx, dy, t;
      longint atan_tab [24] = '{
         'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
         'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
         'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
         'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) << 16;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = rshift_floor(y, i);
         dy = rshift_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      case (ang[15:14])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Apply one item to the bench state; push the expected tensor if any
   function automatic void predict_tensor(cdt_pkg::req_type it);
      cdt_pkg::rsp_type r;
      bit flag;
      longint k, kz, c, s, cc, sc, ss;
      int nr, na;
      flag = 0;
      k = 0;
      kz = 0;
      nr = used_terms(n_radial);
      na = used_terms(n_axial);
      if (it.opcode == cdt_pkg::OP_WR_R) begin
         radial_tab[it.coeff_index] = it.coeff_value;
         return;
      end
      if (it.opcode == cdt_pkg::OP_WR_A) begin
         axial_tab[it.coeff_index] = it.coeff_value;
         return;
      end
      if (it.opcode != cdt_pkg::OP_EVAL) return;
      r = '0;
      if (deriv_mode == cdt_pkg::MODE_VALUE) begin
         k = longint'(horner_value(0, nr, longint'(it.radius), flag));
         kz = longint'(horner_value(1, na, longint'(it.axial_position), flag));
      end else if (deriv_mode == cdt_pkg::MODE_RADIAL) begin
         k = longint'(horner_slope(0, nr, longint'(it.radius), flag));
      end else if (deriv_mode == cdt_pkg::MODE_AXIAL) begin
         kz = longint'(horner_slope(1, na, longint'(it.axial_position), flag));
      end
      if (deriv_mode == cdt_pkg::MODE_VALUE || deriv_mode == cdt_pkg::MODE_RADIAL) begin
         rotate_angle(it.angle, c, s);
         cc = round_q(c * c, 30);
         sc = round_q(s * c, 30);
         ss = round_q(s * s, 30);
         r.tensor_xx = clip32(round_q(cc * k, 30), flag);
         r.tensor_xy = clip32(round_q(sc * k, 30), flag);
         r.tensor_yy = clip32(round_q(ss * k, 30), flag);
      end
      r.tensor_zz = kz[31:0];
      r.saturated = flag;
      tensor_expected.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: random gaps, holds payload while stalled
   // ---------------------------------------------------------------------
   int gap_left;

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
         gap_left <= 0;
         for (int i = 0; i < TERMS_MAX; i++) begin
            radial_tab[i] = (i == 0) ? cdt_pkg::ONE_Q16 : 32'sd0;
            axial_tab[i] = (i == 0) ? cdt_pkg::ONE_Q16 : 32'sd0;
         end
      end else if (req_valid && req_stall) begin
         // hold
      end else begin
         // drop the accepted item from the queue; the next one is at the front
         if (req_valid) begin
            predict_tensor(req_data);
            void'(pending_items.pop_front());
         end
         if (gap_left > 0 || pause_req || pending_items.size() == 0) begin
            req_valid <= 0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_valid <= 1;
            req_data <= pending_items[0];
            gap_left <= pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls and check against oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cdt_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tensor_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected tensor item %h", rsp_data);
            end else begin
               e = tensor_expected.pop_front();
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"tensor mismatch exp xx=%h xy=%h yy=%h zz=%h sat=%b",
                               "\n   got xx=%h xy=%h yy=%h zz=%h sat=%b"},
                              e.tensor_xx, e.tensor_xy, e.tensor_yy, e.tensor_zz,
                              e.saturated,
                              rsp_data.tensor_xx, rsp_data.tensor_xy,
                              rsp_data.tensor_yy, rsp_data.tensor_zz,
                              rsp_data.saturated);
               end
            end
         end
         if (hold_rsp) rsp_stall <= 1;
         else if ($urandom_range(0, 99) < 8) rsp_stall <= 1;
         else if ($urandom_range(0, 99) < 30) rsp_stall <= 0;
         else rsp_stall <= ($urandom_range(0, 99) < 50) ? 0 : rsp_stall;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic cdt_pkg::req_type rand_item(logic [1:0] op);
      cdt_pkg::req_type it;
      it.opcode = op;
      it.radius = 31'($urandom());
      if ($urandom_range(0, 3) != 0) it.radius = 31'($urandom_range(0, 4 << 16));
      it.angle = 16'($urandom());
      it.axial_position = $urandom();
      if ($urandom_range(0, 3) != 0)
         it.axial_position = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      it.coeff_index = 3'($urandom());
      it.coeff_value = $urandom();
      if ($urandom_range(0, 2) != 0)
         it.coeff_value = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      return it;
   endfunction

   task automatic wait_idle();
      wait (pending_items.size() == 0 && !req_valid && tensor_expected.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [3:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= {2'b00, idx};
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx == cdt_pkg::REG_RADIAL_TERMS) n_radial = val;
      else if (idx == cdt_pkg::REG_AXIAL_TERMS) n_axial = val;
      else deriv_mode = val[1:0];
   endtask

   initial begin
      cdt_pkg::req_type it;
      logic [3:0] settings [6][3] = '{
         '{4'd8, 4'd8, 4'd0}, '{4'd0, 4'd15, 4'd1}, '{4'd5, 4'd3, 4'd2},
         '{4'd1, 4'd1, 4'd3}, '{4'd8, 4'd4, 4'd1}, '{4'd3, 4'd8, 4'd0}};
      n_radial = 1;
      n_axial = 1;
      deriv_mode = cdt_pkg::MODE_VALUE;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: reset tables, field extremes, ignored opcode
      it = '0;
      pending_items.push_back(it);
      it.radius = '1; it.angle = '1; it.axial_position = 32'h80000000;
      pending_items.push_back(it);
      it.axial_position = 32'h7FFFFFFF; it.angle = 16'h4000;
      pending_items.push_back(it);
      it.angle = 16'h8000; pending_items.push_back(it);
      it.angle = 16'hC000; pending_items.push_back(it);
      it = '1;
      pending_items.push_back(it);
      for (int i = 0; i < TERMS_MAX; i++) begin
         it = '0; it.opcode = cdt_pkg::OP_WR_R; it.coeff_index = 3'(i);
         it.coeff_value = (i == 7) ? 32'h7FFFFFFF : (i == 3 ? 32'h80000000 : 32'h8000);
         pending_items.push_back(it);
         it.opcode = cdt_pkg::OP_WR_A; it.coeff_value = 32'h10000 - i * 32'h4000;
         pending_items.push_back(it);
      end
      it = '0; it.radius = 31'h30000; it.axial_position = 32'hFFFE0000;
      it.angle = 16'h1234;
      pending_items.push_back(it);
      wait_idle();

      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(cdt_pkg::REG_RADIAL_TERMS, settings[ph][0]);
         write_reg(cdt_pkg::REG_AXIAL_TERMS, settings[ph][1]);
         write_reg(cdt_pkg::REG_DERIV_MODE, settings[ph][2]);
         for (int n = 0; n < 150; n++) begin
            int p;
            p = $urandom_range(0, 99);
            pending_items.push_back(rand_item(p < 65 ? cdt_pkg::OP_EVAL :
                                             p < 80 ? cdt_pkg::OP_WR_R :
                                             p < 97 ? cdt_pkg::OP_WR_A :
                                             cdt_pkg::OP_IGNORE));
            if (ph == 1 && n == 40) begin
               // long receiver hold while the sender keeps offering
               fork
                  begin
                     hold_rsp = 1;
                     repeat (400) @(posedge clock);
                     hold_rsp = 0;
                  end
               join_none
            end
            if (ph == 3 && n == 60) begin
               // sender waits for every outstanding result
               pause_req = 1;
               wait (tensor_expected.size() == 0 && !req_valid);
               pause_req = 0;
            end
            if ($urandom_range(0, 9) == 0) @(posedge clock);
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
